// ----- hw/rtl/ibt_pkg.sv -----
// ibt_pkg: sizes, status codes and state codes for the interval booking table
// no dependencies; used by ibt_ram users and interval_booking_table
`timescale 1ns / 1ps

package ibt_pkg;

  // table size
  localparam int MAX_BOOKINGS = 256;
  localparam int ADDR_W = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
  localparam int CNT_W = $clog2(MAX_BOOKINGS + 1);
  localparam int TIME_W = 32;
  localparam int ENTRY_W = 2 * TIME_W;

  // result codes
  localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
  localparam logic [1:0] STATUS_OVERLAP   = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED = 2'd3;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

endpackage

// ----- hw/rtl/ibt_ram.sv -----
// ibt_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ibt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/interval_booking_table.sv -----
// interval_booking_table: half-open interval reservation table, scan and insert
// depends on ibt_pkg and ibt_ram
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_start_time, in_end_time
//   out     | output    | out_valid / out_ready  | out_status
//
// with n = booked_count, the scan reads up to n stored intervals (at most
// MAX_BOOKINGS), one per cycle through the single read port of the table ram,
// and an overlap at entry k ends it early. a malformed request skips the scan
// and goes straight to the result state. reset clears the fill count and the
// control registers but not the table ram, so no clearing pass is needed.
// a new request is taken only once the previous result is in the output
// register; out_ready low holds the finished result and stalls the controller.
`timescale 1ns / 1ps

module interval_booking_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_start_time,
  input  logic [31:0] in_end_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status
);

  logic [1:0]                  state_r, state_nxt;
  logic [ibt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ibt_pkg::CNT_W-1:0]   issue_r, issue_nxt;
  logic                        pend_r, pend_nxt;
  logic [ibt_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [ibt_pkg::TIME_W-1:0]  end_r, end_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;

  logic                        rd_en;
  logic                        mem_we;
  logic [ibt_pkg::ENTRY_W-1:0] rd_data;
  logic [ibt_pkg::TIME_W-1:0]  rd_start;
  logic [ibt_pkg::TIME_W-1:0]  rd_end;
  logic                        hit;
  logic                        in_fire;

  // interval table: start in the upper half, end in the lower half
  ibt_ram #(
    .WIDTH(ibt_pkg::ENTRY_W),
    .DEPTH(ibt_pkg::MAX_BOOKINGS)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count_r[ibt_pkg::ADDR_W-1:0]),
    .wdata({start_r, end_r}),
    .re   (rd_en),
    .raddr(issue_r[ibt_pkg::ADDR_W-1:0]),
    .rdata(rd_data)
  );

  assign rd_start = rd_data[ibt_pkg::ENTRY_W-1:ibt_pkg::TIME_W];
  assign rd_end   = rd_data[ibt_pkg::TIME_W-1:0];

  // overlap test on the entry returned this cycle
  assign hit = pend_r && (start_r < rd_end) && (rd_start < end_r);

  assign in_ready   = (state_r == ibt_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // controller
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    start_nxt      = start_r;
    end_nxt        = end_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      ibt_pkg::ST_IDLE: begin
        if (in_fire) begin
          start_nxt = in_start_time;
          end_nxt   = in_end_time;
          issue_nxt = '0;
          if (in_start_time >= in_end_time) begin
            status_nxt = ibt_pkg::STATUS_MALFORMED;
            state_nxt  = ibt_pkg::ST_RESULT;
          end else begin
            state_nxt = ibt_pkg::ST_SCAN;
          end
        end
      end
      ibt_pkg::ST_SCAN: begin
        rd_en     = (issue_r < count_r) && !hit;
        pend_nxt  = rd_en;
        issue_nxt = rd_en ? issue_r + 1'b1 : issue_r;
        priority if (hit) begin
          status_nxt = ibt_pkg::STATUS_OVERLAP;
          state_nxt  = ibt_pkg::ST_RESULT;
        end else if (!rd_en && !pend_r) begin
          // scan finished without overlap
          if (count_r == ibt_pkg::CNT_W'(ibt_pkg::MAX_BOOKINGS)) begin
            status_nxt = ibt_pkg::STATUS_FULL;
          end else begin
            mem_we     = 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = ibt_pkg::STATUS_ACCEPTED;
          end
          state_nxt = ibt_pkg::ST_RESULT;
        end
      end
      ibt_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = ibt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ibt_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ibt_pkg::ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ibt_pkg::CNT_W'(ibt_pkg::MAX_BOOKINGS))
    else $error("fill count beyond table size");

  a_write_grows_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("table write without count increment");

  a_malformed_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_start_time >= in_end_time)) |=>
      (state_r == ibt_pkg::ST_RESULT && status_r == ibt_pkg::STATUS_MALFORMED))
    else $error("malformed request not reported at once");

  a_no_read_past_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (issue_r < count_r && state_r == ibt_pkg::ST_SCAN))
    else $error("read of unwritten table entry");
`endif

endmodule
